// ===== src/dhq_pkg.sv =====
// Package: types, constants and state encoding for the d-ary min-heap queue.
package dhq_pkg;

    localparam int Capacity     = 256;
    localparam int KeyWidth     = 16;
    localparam int PayloadWidth = 16;
    localparam int MaxArity     = 8;
    localparam int MinArity     = 2;
    localparam int AddrWidth    = $clog2(Capacity);
    localparam int CountWidth   = $clog2(Capacity + 1);
    localparam int ArityWidth   = 4;
    localparam int EntryWidth   = KeyWidth + PayloadWidth;
    // Widths for the child-index product, pos * arity + 1.
    localparam int ProdWidth    = AddrWidth + ArityWidth + 1;

    localparam logic       KIND_INSERT  = 1'b0;
    localparam logic       KIND_REMOVE  = 1'b1;
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic                    kind;
        logic [KeyWidth-1:0]     key;
        logic [PayloadWidth-1:0] payload;
    } t_in_item;

    typedef struct packed {
        logic [1:0]              status;
        logic [KeyWidth-1:0]     out_key;
        logic [PayloadWidth-1:0] out_payload;
        logic [CountWidth-1:0]   count;
    } t_out_item;

    typedef struct packed {
        logic [KeyWidth-1:0]     key;
        logic [PayloadWidth-1:0] payload;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,     // read parent of the moving entry
        ST_UP_CMP,    // compare parent with moving entry
        ST_DN_LAST,   // read last entry to move it to the root
        ST_DN_LASTW,  // latch last entry
        ST_DN_CH_RD,  // issue read of one child
        ST_DN_CH_CMP, // compare returned child against the best so far
        ST_DN_DEC,    // decide swap for the level
        ST_ROOT_RD,   // read root for the result
        ST_ROOT_W,    // root data valid
        ST_DONE
    } t_state;

endpackage

// ===== src/dhq_ram.sv =====
// Generic single-port RAM with registered read.
module dhq_ram #(
    parameter int Width = 32,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // Write-first is not needed: read and write never target the same cycle's use.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/dary_min_heap_queue.sv =====
// Top level: d-ary min-heap priority queue with a sequenced sift over one RAM.
//
//  channel | signals                     | transfer
//  --------+-----------------------------+-------------------------------
//  command | i_start, o_busy, i_cmd      | edge with i_start & !o_busy
//  result  | o_done, o_result            | edge ending the o_done cycle
//  config  | i_cfg_we, i_cfg_wdata       | edge with i_cfg_we (arity)
//
// Steps: an insert climbs one level per parent read and compare, stopping at
// the root or at a parent whose key is not larger; a remove reads the root and
// the last entry, then per level examined reads up to arity children one at a
// time; an empty remove goes straight to the result, a dropped insert via a root read.
// The single RAM port sets the pace: one entry read or written per cycle.
// Reset clears the count to 0 and sets arity to 2; the heap store is not cleared.
// o_busy is high from the accepting edge until the result cycle begins;
// the receiver cannot stall, a result is shown for one cycle only.
module dary_min_heap_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  dhq_pkg::t_in_item           i_cmd,
    output logic                        o_done,
    output dhq_pkg::t_out_item          o_result,
    input  logic                        i_cfg_we,
    input  logic [dhq_pkg::ArityWidth-1:0] i_cfg_wdata
);
    import dhq_pkg::*;

    t_state                  r_state, n_state;
    logic [ArityWidth-1:0]   r_arity;
    logic [CountWidth-1:0]   r_count, n_count;
    logic [AddrWidth-1:0]    r_pos, n_pos;       // current position of moving entry
    t_entry                  r_mov, n_mov;       // moving entry
    logic [ProdWidth-1:0]    r_child, n_child;   // child index under test
    logic [ArityWidth-1:0]   r_ci, n_ci;         // child number in level
    logic [AddrWidth-1:0]    r_best, n_best;
    t_entry                  r_bent, n_bent;
    logic                    r_bvalid, n_bvalid;
    logic                    r_kind, n_kind;
    logic [1:0]              r_status, n_status;
    t_entry                  r_rent, n_rent;     // entry returned to the user
    t_out_item               r_res, n_res;
    logic                    r_done, n_done;

    logic                    ram_we;
    logic [AddrWidth-1:0]    ram_addr;
    t_entry                  ram_wdata;
    logic [EntryWidth-1:0]   ram_rdata;
    t_entry                  rd_ent;

    logic [ArityWidth-1:0]   eff_arity;
    logic [AddrWidth-1:0]    parent;
    logic                    accept;

    dhq_ram #(.Width(EntryWidth), .Depth(Capacity)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign rd_ent = t_entry'(ram_rdata);
    assign accept = i_start && (r_state == ST_IDLE);
    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_result = r_res;

    // Arity clamp into the legal range
    always_comb begin
        if (r_arity < ArityWidth'(MinArity)) begin
            eff_arity = ArityWidth'(MinArity);
        end else if (r_arity > ArityWidth'(MaxArity)) begin
            eff_arity = ArityWidth'(MaxArity);
        end else begin
            eff_arity = r_arity;
        end
    end

    // Parent index (pos-1)/d by reciprocal multiplication, exact for 8-bit positions
    always_comb begin
        logic [AddrWidth-1:0] pm1;
        logic [8:0]           recip;
        logic [3:0]           rshift;
        logic [16:0]          pq;
        pm1 = r_pos - AddrWidth'(1);
        case (eff_arity)
            4'd2: begin recip = 9'd256; rshift = 4'd9;  end
            4'd3: begin recip = 9'd171; rshift = 4'd9;  end
            4'd4: begin recip = 9'd256; rshift = 4'd10; end
            4'd5: begin recip = 9'd205; rshift = 4'd10; end
            4'd6: begin recip = 9'd171; rshift = 4'd10; end
            4'd7: begin recip = 9'd293; rshift = 4'd11; end
            4'd8: begin recip = 9'd256; rshift = 4'd11; end
            default: begin recip = 9'd256; rshift = 4'd9; end
        endcase
        pq     = 17'(pm1) * 17'(recip);
        parent = AddrWidth'(pq >> rshift);
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arity <= ArityWidth'(MinArity);
        end else if (i_cfg_we) begin
            r_arity <= i_cfg_wdata;
        end
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_mov    <= n_mov;
        r_child  <= n_child;
        r_ci     <= n_ci;
        r_best   <= n_best;
        r_bent   <= n_bent;
        r_bvalid <= n_bvalid;
        r_kind   <= n_kind;
        r_status <= n_status;
        r_rent   <= n_rent;
        r_res    <= n_res;
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_pos    = r_pos;
        n_mov    = r_mov;
        n_child  = r_child;
        n_ci     = r_ci;
        n_best   = r_best;
        n_bent   = r_bent;
        n_bvalid = r_bvalid;
        n_kind   = r_kind;
        n_status = r_status;
        n_rent   = r_rent;
        n_res    = r_res;
        n_done   = 1'b0;
        ram_we   = 1'b0;
        ram_addr = r_pos;
        ram_wdata = r_mov;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_kind   = i_cmd.kind;
                    n_status = STATUS_OK;
                    n_rent   = '0;
                    if (i_cmd.kind == KIND_INSERT) begin
                        if (r_count >= CountWidth'(Capacity)) begin
                            n_status = STATUS_FULL;
                            n_state  = ST_ROOT_RD;
                        end else begin
                            n_pos         = r_count[AddrWidth-1:0];
                            n_mov.key     = i_cmd.key;
                            n_mov.payload = i_cmd.payload;
                            n_count       = r_count + CountWidth'(1);
                            n_state       = ST_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = STATUS_EMPTY;
                            n_state  = ST_DONE;
                        end else begin
                            n_count = r_count - CountWidth'(1);
                            n_pos   = '0;
                            n_state = ST_ROOT_RD;
                        end
                    end
                end
            end
            // Sift up: read parent, then swap down or place
            ST_UP_RD: begin
                if (r_pos == '0) begin
                    ram_we   = 1'b1;
                    n_state  = ST_ROOT_RD;
                end else begin
                    ram_addr = parent;
                    n_child  = ProdWidth'(parent);
                    n_state  = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                if (rd_ent.key > r_mov.key) begin
                    ram_we    = 1'b1;
                    ram_wdata = rd_ent;
                    n_pos     = r_child[AddrWidth-1:0];
                    n_state   = ST_UP_RD;
                end else begin
                    ram_we  = 1'b1;
                    n_state = ST_ROOT_RD;
                end
            end
            // Root read: for insert the result, for remove the returned entry
            ST_ROOT_RD: begin
                ram_addr = '0;
                n_state  = ST_ROOT_W;
            end
            ST_ROOT_W: begin
                if (r_kind == KIND_REMOVE && r_status == STATUS_OK && r_bvalid == 1'b0
                        && r_pos == '0 && r_child != ProdWidth'(Capacity)) begin
                    // first pass of remove: keep the root, fetch the last entry
                    n_rent   = rd_ent;
                    n_child  = ProdWidth'(Capacity);
                    n_state  = ST_DN_LAST;
                end else begin
                    if (r_kind == KIND_INSERT && r_count != '0) begin
                        n_rent = rd_ent;
                    end
                    n_state = ST_DONE;
                end
            end
            ST_DN_LAST: begin
                ram_addr = r_count[AddrWidth-1:0];
                n_state  = ST_DN_LASTW;
            end
            ST_DN_LASTW: begin
                n_mov   = rd_ent;
                n_pos   = '0;
                n_state = ST_DN_DEC;
                n_bvalid = 1'b0;
                n_ci     = '0;
                // when the heap is now empty nothing moves
                if (r_count == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_child = ProdWidth'(1);
                    n_state = ST_DN_CH_RD;
                end
            end
            // Sift down: scan children one at a time
            ST_DN_CH_RD: begin
                if (r_ci < eff_arity && r_child < ProdWidth'(r_count)) begin
                    ram_addr = r_child[AddrWidth-1:0];
                    n_state  = ST_DN_CH_CMP;
                end else begin
                    n_state = ST_DN_DEC;
                end
            end
            ST_DN_CH_CMP: begin
                if (!r_bvalid || rd_ent.key < r_bent.key) begin
                    n_bent   = rd_ent;
                    n_best   = r_child[AddrWidth-1:0];
                    n_bvalid = 1'b1;
                end
                n_child = r_child + ProdWidth'(1);
                n_ci    = r_ci + ArityWidth'(1);
                n_state = ST_DN_CH_RD;
            end
            ST_DN_DEC: begin
                if (r_bvalid && r_mov.key > r_bent.key) begin
                    ram_we    = 1'b1;
                    ram_wdata = r_bent;
                    n_pos     = r_best;
                    n_bvalid  = 1'b0;
                    n_ci      = '0;
                    n_state   = ST_DN_CH_RD;
                    n_child   = ProdWidth'(r_best) * ProdWidth'(eff_arity) + ProdWidth'(1);
                end else begin
                    ram_we  = 1'b1;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_res.status      = r_status;
                n_res.out_key     = r_rent.key;
                n_res.out_payload = r_rent.payload;
                n_res.count       = r_count;
                n_done            = 1'b1;
                n_child           = '0;
                n_bvalid          = 1'b0;
                n_state           = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // The result strobe only follows the final sequencer step
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_state) == ST_DONE)
        else $error("result strobe without completion");

    // Count never exceeds capacity
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountWidth'(Capacity))
        else $error("count beyond capacity");

    // An empty-heap error reports zero count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == STATUS_EMPTY) |-> o_result.count == '0)
        else $error("empty status with nonzero count");

    // No RAM write while idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !ram_we)
        else $error("heap written while idle");

endmodule
